FILE: src/sop_pkg.sv
// Shared types, codes and product-closing logic for the sum-of-products validator.
`timescale 1ns / 1ps
`default_nettype none

package sop_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned SYM_W    = 7;
    localparam int unsigned MASK_W   = 64;
    localparam int unsigned VAR_W    = 6;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CHAR_W-1:0]  SPACE_CODE = 8'd32;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_SYMBOL      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEGATION_SYMBOL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VARIABLE_MASK   = 2'd2;

    localparam logic [SYM_W-1:0]  SUM_SYMBOL_RESET      = 7'd43;
    localparam logic [SYM_W-1:0]  NEGATION_SYMBOL_RESET = 7'd39;
    localparam logic [MASK_W-1:0] VARIABLE_MASK_RESET   = 64'h07FF_FFFE_07FF_FFFE;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY        = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_SUM_AT_EDGE  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY_TERM   = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_BAD_PRODUCT  = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_REPEATED_VAR = 3'd5;
    localparam logic [STATUS_W-1:0] STATUS_SETS_DIFFER  = 3'd6;

    // Sticky product error codes
    localparam logic [1:0] PERR_NONE     = 2'd0;
    localparam logic [1:0] PERR_BAD      = 2'd1;
    localparam logic [1:0] PERR_REPEATED = 2'd2;

    typedef struct packed {
        logic               is_space;
        logic               is_sum;
        logic               is_neg;
        logic               is_var;
        logic               is_bad;
        logic [VAR_W-1:0]   var_idx;
    } sop_class_t;

    typedef struct packed {
        logic [MASK_W-1:0]  cur_mask;
        logic [MASK_W-1:0]  first_mask;
        logic               in_first;
        logic               seen;
        logic               prev_sum;
        logic               pend_neg;
        logic               edge_err;
        logic               empty_err;
        logic [1:0]         perr;
        logic               differ;
        logic [COUNT_W-1:0] count;
    } sop_state_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [MASK_W-1:0]   used;
        logic [COUNT_W-1:0]  count;
    } sop_result_t;

    localparam sop_state_t STATE_RESET = '{
        cur_mask:   '0,
        first_mask: '0,
        in_first:   1'b1,
        seen:       1'b0,
        prev_sum:   1'b0,
        pend_neg:   1'b0,
        edge_err:   1'b0,
        empty_err:  1'b0,
        perr:       PERR_NONE,
        differ:     1'b0,
        count:      '0
    };

    // End the current product: check for a trailing negation, latch or compare
    // the variable set, advance the saturating product count.
    function automatic sop_state_t close_product(input sop_state_t s);
        sop_state_t r;
        r = s;
        if (s.pend_neg && (s.perr == PERR_NONE))
        begin
            r.perr = PERR_BAD;
        end
        if (s.in_first)
        begin
            r.first_mask = s.cur_mask;
            r.in_first   = 1'b0;
        end
        else if (s.cur_mask != s.first_mask)
        begin
            r.differ = 1'b1;
        end
        r.cur_mask = '0;
        r.pend_neg = 1'b0;
        if (s.count != COUNT_MAX)
        begin
            r.count = s.count + 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/sop_classify.sv
// Character classifier: space, sum, negation, accepted variable or bad character.
`timescale 1ns / 1ps
`default_nettype none

module sop_classify
    import sop_pkg::*;
(
    input  wire logic [CHAR_W-1:0] text_char,
    input  wire logic [SYM_W-1:0]  sum_symbol,
    input  wire logic [SYM_W-1:0]  negation_symbol,
    input  wire logic [MASK_W-1:0] variable_mask,
    output sop_class_t             char_class
);

    logic space_hit;
    logic sum_hit;
    logic neg_hit;
    logic var_range;
    logic var_hit;

    // Sum wins over negation, negation wins over the variable mask
    assign space_hit = (text_char == SPACE_CODE);
    assign sum_hit   = !space_hit && (text_char == {1'b0, sum_symbol});
    assign neg_hit   = !space_hit && !sum_hit && (text_char == {1'b0, negation_symbol});
    assign var_range = (text_char[CHAR_W-1:VAR_W] == 2'b01);
    assign var_hit   = !space_hit && !sum_hit && !neg_hit && var_range
                       && variable_mask[text_char[VAR_W-1:0]];

    always_comb
    begin
        char_class.is_space = space_hit;
        char_class.is_sum   = sum_hit;
        char_class.is_neg   = neg_hit;
        char_class.is_var   = var_hit;
        char_class.is_bad   = !space_hit && !sum_hit && !neg_hit && !var_hit;
        char_class.var_idx  = text_char[VAR_W-1:0];
    end

endmodule

`default_nettype wire

FILE: src/sop_core.sv
// Parser state register, per-character update and end-of-expression status.
`timescale 1ns / 1ps
`default_nettype none

module sop_core
    import sop_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  wire logic        last_char,
    input  wire sop_class_t  char_class,
    output sop_result_t      result,
    output logic             state_seen
);

    sop_state_t state_reg;
    sop_state_t state_next;
    sop_state_t after_char;
    sop_state_t final_state;
    logic [MASK_W-1:0] var_bit;

    assign var_bit = {{(MASK_W-1){1'b0}}, 1'b1} << char_class.var_idx;

    // Apply one character to the state
    always_comb
    begin
        after_char = state_reg;
        if (!char_class.is_space)
        begin
            if (char_class.is_sum)
            begin
                if (!state_reg.seen)
                begin
                    after_char.edge_err = 1'b1;
                end
                else if (state_reg.prev_sum)
                begin
                    after_char.empty_err = 1'b1;
                end
                after_char          = close_product(after_char);
                after_char.prev_sum = 1'b1;
            end
            else
            begin
                if (char_class.is_neg)
                begin
                    after_char.pend_neg = 1'b1;
                end
                else if (char_class.is_var)
                begin
                    if (((state_reg.cur_mask & var_bit) != '0) && (state_reg.perr == PERR_NONE))
                    begin
                        after_char.perr = PERR_REPEATED;
                    end
                    after_char.cur_mask = state_reg.cur_mask | var_bit;
                    after_char.pend_neg = 1'b0;
                end
                else if (state_reg.perr == PERR_NONE)
                begin
                    after_char.perr = PERR_BAD;
                end
                after_char.prev_sum = 1'b0;
            end
            after_char.seen = 1'b1;
        end
    end

    // Close out the expression and rank the errors
    always_comb
    begin
        final_state = after_char;
        final_state.edge_err = after_char.edge_err | after_char.prev_sum;
        final_state = close_product(final_state);

        result.used  = final_state.first_mask;
        result.count = final_state.count;
        priority if (!after_char.seen)
        begin
            result.status = STATUS_EMPTY;
            result.used   = '0;
            result.count  = '0;
        end
        else if (final_state.edge_err)
        begin
            result.status = STATUS_SUM_AT_EDGE;
        end
        else if (final_state.empty_err)
        begin
            result.status = STATUS_EMPTY_TERM;
        end
        else if (final_state.perr == PERR_BAD)
        begin
            result.status = STATUS_BAD_PRODUCT;
        end
        else if (final_state.perr == PERR_REPEATED)
        begin
            result.status = STATUS_REPEATED_VAR;
        end
        else if (final_state.differ)
        begin
            result.status = STATUS_SETS_DIFFER;
        end
        else
        begin
            result.status = STATUS_OK;
        end
    end

    // Start fresh after the last character of an expression
    assign state_next = last_char ? STATE_RESET : after_char;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    assign state_seen = state_reg.seen;

endmodule

`default_nettype wire

FILE: src/sum_of_products_validator.sv
// Top level of the sum-of-products validator: config registers, handshake, result register.
// Usage:
//   Input channel (in_valid / in_stall, text_char, last_char) carries one
//   character per transfer. Spaces are dropped. The character flagged with
//   last_char closes the expression and produces exactly one result.
//   Output channel (out_valid / out_stall, status, variables_used,
//   term_count) carries that result; characters that are not last
//   produce nothing.
//   Throughput: one character per cycle while in_stall is low. The result is
//   presented the cycle after the last character transfers (one register stage).
//   Per-character work is a classify step and a flag/mask update feeding the
//   parser state register; the last character also closes the final product
//   and ranks errors in the same cycle, straight into the result register.
//   Stall: while a result sits in the output register and out_stall is high,
//   in_stall is raised; otherwise input keeps flowing, including in the
//   cycle the held result drains.
//   Reset (rst_n low, asynchronous): parser state clears, output register
//   empties, configuration returns to '+', '\'' and letters A-Z, a-z.
//   Configuration: write cfg_data to register cfg_index with cfg_write while
//   idle; index 3 is ignored.
`timescale 1ns / 1ps
`default_nettype none

module sum_of_products_validator
    import sop_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write port
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [MASK_W-1:0]     cfg_data,
    // character input
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [CHAR_W-1:0]     text_char,
    input  wire logic                  last_char,
    // status output
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [STATUS_W-1:0]        status,
    output logic [MASK_W-1:0]          variables_used,
    output logic [COUNT_W-1:0]         term_count
);

    logic [SYM_W-1:0]  sum_symbol_reg;
    logic [SYM_W-1:0]  negation_symbol_reg;
    logic [MASK_W-1:0] variable_mask_reg;

    sop_class_t  char_class;
    sop_result_t core_result;
    sop_result_t result_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        in_accept;
    logic        result_load;
    logic        state_seen;

    // Configuration registers; unknown index drops the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_symbol_reg      <= SUM_SYMBOL_RESET;
            negation_symbol_reg <= NEGATION_SYMBOL_RESET;
            variable_mask_reg   <= VARIABLE_MASK_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SUM_SYMBOL:      sum_symbol_reg      <= cfg_data[SYM_W-1:0];
                CFG_NEGATION_SYMBOL: negation_symbol_reg <= cfg_data[SYM_W-1:0];
                CFG_VARIABLE_MASK:   variable_mask_reg   <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Hold input only while a finished result is blocked downstream
    assign in_stall    = out_valid_reg && out_stall;
    assign in_accept   = in_valid && !in_stall;
    assign result_load = in_accept && last_char;

    sop_classify u_classify (
        .text_char       (text_char),
        .sum_symbol      (sum_symbol_reg),
        .negation_symbol (negation_symbol_reg),
        .variable_mask   (variable_mask_reg),
        .char_class      (char_class)
    );

    sop_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (in_accept),
        .last_char  (last_char),
        .char_class (char_class),
        .result     (core_result),
        .state_seen (state_seen)
    );

    // Output register: load on the last character, drop once transferred
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            result_reg <= core_result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = result_reg.status;
    assign variables_used = result_reg.used;
    assign term_count     = result_reg.count;

    // A result only appears right after a last character transfers
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_accept && last_char))
        else $error("result appeared without a last character");

    // Parser starts the next expression clean
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && last_char) |=> !state_seen)
        else $error("parser state not cleared after last character");

    // Empty expression carries no products and no variables
    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (result_reg.status == STATUS_EMPTY))
            |-> ((result_reg.count == '0) && (result_reg.used == '0)))
        else $error("empty status with nonzero fields");

    // Any non-empty expression has at least one product
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (result_reg.status != STATUS_EMPTY)) |-> (result_reg.count != '0))
        else $error("non-empty status with zero product count");

endmodule

`default_nettype wire

FILE: sim/sop_status_checker.sv
// Checker for the sum-of-products validator: watches both channels, predicts and compares status, set and count.
`timescale 1ns / 1ps

module sop_status_checker
    import sop_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [MASK_W-1:0]    cfg_data,
    input  wire logic                 in_valid,
    input  wire logic                 in_stall,
    input  wire logic [CHAR_W-1:0]    text_char,
    input  wire logic                 last_char,
    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire logic [STATUS_W-1:0]  status,
    input  wire logic [MASK_W-1:0]    variables_used,
    input  wire logic [COUNT_W-1:0]   term_count,
    output int                        pending,
    output int                        failures
);

    typedef struct packed {
        logic [MASK_W-1:0]  var_set;
        logic [MASK_W-1:0]  first_set;
        logic               in_first_term;
        logic               any_char;
        logic               after_sum;
        logic               neg_pending;
        logic               edge_flag;
        logic               empty_flag;
        logic [1:0]         term_fault;
        logic               differ_flag;
        logic [COUNT_W-1:0] terms;
    } parse_state_t;

    logic [SYM_W-1:0]  sum_sym;
    logic [SYM_W-1:0]  neg_sym;
    logic [MASK_W-1:0] var_accept;
    parse_state_t      parse;
    sop_result_t       status_q[$];
    int                mismatches;

    function automatic parse_state_t fresh_parse();
        parse_state_t r;
        r = '0;
        r.in_first_term = 1'b1;
        return r;
    endfunction

    // End a product: flag a dangling negation, latch or compare its variable set.
    function automatic parse_state_t close_term(input parse_state_t s);
        parse_state_t r;
        r = s;
        if (s.neg_pending && (s.term_fault == PERR_NONE))
        begin
            r.term_fault = PERR_BAD;
        end
        if (s.in_first_term)
        begin
            r.first_set     = s.var_set;
            r.in_first_term = 1'b0;
        end
        else if (s.var_set != s.first_set)
        begin
            r.differ_flag = 1'b1;
        end
        r.var_set     = '0;
        r.neg_pending = 1'b0;
        if (s.terms != COUNT_MAX)
        begin
            r.terms = s.terms + 1'b1;
        end
        return r;
    endfunction

    // Advance the parser by one character; queue a status on the last one.
    task automatic absorb_char(input logic [CHAR_W-1:0] c, input logic is_last);
        sop_result_t r;
        if (c != SPACE_CODE)
        begin
            if (c == {1'b0, sum_sym})
            begin
                if (!parse.any_char)
                begin
                    parse.edge_flag = 1'b1;
                end
                else if (parse.after_sum)
                begin
                    parse.empty_flag = 1'b1;
                end
                parse = close_term(parse);
                parse.after_sum = 1'b1;
            end
            else
            begin
                if (c == {1'b0, neg_sym})
                begin
                    parse.neg_pending = 1'b1;
                end
                else if ((c[7:6] == 2'b01) && var_accept[c[5:0]])
                begin
                    if (parse.var_set[c[5:0]] && (parse.term_fault == PERR_NONE))
                    begin
                        parse.term_fault = PERR_REPEATED;
                    end
                    parse.var_set[c[5:0]] = 1'b1;
                    parse.neg_pending     = 1'b0;
                end
                else if (parse.term_fault == PERR_NONE)
                begin
                    parse.term_fault = PERR_BAD;
                end
                parse.after_sum = 1'b0;
            end
            parse.any_char = 1'b1;
        end
        if (is_last)
        begin
            r = '0;
            if (!parse.any_char)
            begin
                r.status = STATUS_EMPTY;
            end
            else
            begin
                if (parse.after_sum)
                begin
                    parse.edge_flag = 1'b1;
                end
                parse = close_term(parse);
                if (parse.edge_flag)
                    r.status = STATUS_SUM_AT_EDGE;
                else if (parse.empty_flag)
                    r.status = STATUS_EMPTY_TERM;
                else if (parse.term_fault == PERR_BAD)
                    r.status = STATUS_BAD_PRODUCT;
                else if (parse.term_fault == PERR_REPEATED)
                    r.status = STATUS_REPEATED_VAR;
                else if (parse.differ_flag)
                    r.status = STATUS_SETS_DIFFER;
                else
                    r.status = STATUS_OK;
                r.used  = parse.first_set;
                r.count = parse.terms;
            end
            status_q.push_back(r);
            parse = fresh_parse();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        sop_result_t want;
        if (!rst_n)
        begin
            sum_sym    = SUM_SYMBOL_RESET;
            neg_sym    = NEGATION_SYMBOL_RESET;
            var_accept = VARIABLE_MASK_RESET;
            parse      = fresh_parse();
            status_q.delete();
            mismatches = 0;
        end
        else
        begin
            // a result leaves before any new last character is absorbed
            if (out_valid && !out_stall)
            begin
                if (status_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected status %0d used %h count %0d",
                                 $realtime, status, variables_used, term_count);
                end
                else
                begin
                    want = status_q.pop_front();
                    if ((want.status !== status) || (want.used !== variables_used) ||
                        (want.count !== term_count))
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected %0d/%h/%0d, got %0d/%h/%0d",
                                     $realtime, want.status, want.used, want.count,
                                     status, variables_used, term_count);
                    end
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_SUM_SYMBOL:      sum_sym    = cfg_data[SYM_W-1:0];
                    CFG_NEGATION_SYMBOL: neg_sym    = cfg_data[SYM_W-1:0];
                    CFG_VARIABLE_MASK:   var_accept = cfg_data;
                    default:             ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                absorb_char(text_char, last_char);
            end
        end
        pending  <= status_q.size();
        failures <= mismatches;
    end

endmodule

FILE: sim/tb.sv
// Testbench top for the sum-of-products validator: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb;
    import sop_pkg::*;

    // Index past the last register; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int RANDOM_CHARS  = 1600;
    localparam int CFG_SWITCH    = 200;
    localparam int SETTING_COUNT = 6;
    localparam int DRAIN_CYCLES  = 4;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [MASK_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [CHAR_W-1:0]    text_char = '0;
    logic                 last_char = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [MASK_W-1:0]    variables_used;
    logic [COUNT_W-1:0]   term_count;

    int pending;
    int failures;
    int send_idle_pct = 17;
    int recv_idle_pct = 50;

    // Mirror of the register contents, used only to shape the stimulus
    logic [SYM_W-1:0]  cur_sum = SUM_SYMBOL_RESET;
    logic [SYM_W-1:0]  cur_neg = NEGATION_SYMBOL_RESET;
    logic [MASK_W-1:0] cur_accept = VARIABLE_MASK_RESET;

    // Characters of the expression about to be sent
    logic [CHAR_W-1:0] expr_q[$];

    sum_of_products_validator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .text_char      (text_char),
        .last_char      (last_char),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .variables_used (variables_used),
        .term_count     (term_count)
    );

    sop_status_checker status_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .text_char      (text_char),
        .last_char      (last_char),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .variables_used (variables_used),
        .term_count     (term_count),
        .pending        (pending),
        .failures       (failures)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

    // Receiver: stall at random, independent of anything the block does
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Offer one character and hold it until the transfer happens. Valid stays
    // high on return, so back-to-back characters drop it only for random idle gaps.
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_char <= c;
        last_char <= is_last;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Send the queued expression, flagging its final character as last
    task automatic send_expr();
        foreach (expr_q[i])
        begin
            send_char(expr_q[i], i == expr_q.size() - 1);
        end
    endtask

    // Drop valid and wait until every predicted status has come out, then let
    // the output register settle before anything touches the registers.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            expr_q.push_back(s[i]);
        end
    endtask

    // Append a character, now and then followed by a space to be dropped
    task automatic push_char(input logic [CHAR_W-1:0] c);
        expr_q.push_back(c);
        if ($urandom_range(9) == 0)
        begin
            expr_q.push_back(SPACE_CODE);
        end
    endtask

    // Write all three registers plus the spare index. Symbol writes carry
    // random upper bits, which the block must ignore.
    task automatic apply_setting(input int which);
        logic [SYM_W-1:0]  s;
        logic [SYM_W-1:0]  n;
        logic [MASK_W-1:0] m;
        logic [MASK_W-1:0] word;
        case (which)
            1:       begin s = 7'd0;   n = 7'd127; m = '1; end
            2:       begin s = 7'd127; n = 7'd0;   m = '0; end
            // sum symbol is a space and never matches; negation collides with 'A'
            3:       begin s = SPACE_CODE[SYM_W-1:0]; n = 7'd65; m = VARIABLE_MASK_RESET; end
            // sum and negation collide; sum wins
            4:       begin s = 7'd42;  n = 7'd42;  m = {$urandom, $urandom}; end
            5:       begin
                         s = 7'($urandom_range(127));
                         n = 7'($urandom_range(127));
                         m = {$urandom, $urandom};
                     end
            default: begin s = SUM_SYMBOL_RESET; n = NEGATION_SYMBOL_RESET;
                           m = VARIABLE_MASK_RESET; end
        endcase
        word = {$urandom, $urandom};
        word[SYM_W-1:0] = s;
        cfg_write <= 1'b1;
        cfg_index <= CFG_SUM_SYMBOL;
        cfg_data  <= word;
        @(posedge clk);
        word = {$urandom, $urandom};
        word[SYM_W-1:0] = n;
        cfg_index <= CFG_NEGATION_SYMBOL;
        cfg_data  <= word;
        @(posedge clk);
        cfg_index <= CFG_VARIABLE_MASK;
        cfg_data  <= m;
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_data  <= {$urandom, $urandom};
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_sum    = s;
        cur_neg    = n;
        cur_accept = m;
    endtask

    // Build one random expression. Most are well-formed products over one
    // variable set with random order and negations; some get a single defect
    // and the rest is raw noise or spaces only.
    task automatic build_random_expr();
        logic [CHAR_W-1:0] accepted[$];
        logic [CHAR_W-1:0] term_vars[$];
        logic [CHAR_W-1:0] tmp;
        int kind;
        int width;
        int terms;
        int pos;
        expr_q.delete();
        // usable variables: accepted and not shadowed by either symbol
        for (int k = 0; k < MASK_W; k++)
        begin
            tmp = 8'(64 + k);
            if (cur_accept[k] && (tmp != {1'b0, cur_sum}) && (tmp != {1'b0, cur_neg}))
            begin
                accepted.push_back(tmp);
            end
        end
        kind  = $urandom_range(99);
        width = $urandom_range(1, 6);
        if (kind >= 96)
        begin
            repeat (width) expr_q.push_back(SPACE_CODE);
        end
        else if ((accepted.size() == 0) || (kind >= 80))
        begin
            // noise over the whole byte range, mixed with symbols and spaces
            repeat (width)
            begin
                case ($urandom_range(4))
                    0:       push_char({1'b0, cur_sum});
                    1:       push_char({1'b0, cur_neg});
                    2:       push_char(8'($urandom_range(64, 127)));
                    3:       push_char(SPACE_CODE);
                    default: push_char(8'($urandom_range(255)));
                endcase
            end
        end
        else
        begin
            width = $urandom_range(1, (accepted.size() < 4) ? accepted.size() : 4);
            for (int j = 0; j < width; j++)
            begin
                pos = $urandom_range(j, accepted.size() - 1);
                tmp = accepted[j];
                accepted[j] = accepted[pos];
                accepted[pos] = tmp;
                term_vars.push_back(accepted[j]);
            end
            terms = $urandom_range(1, 4);
            for (int t = 0; t < terms; t++)
            begin
                if (t > 0)
                begin
                    push_char({1'b0, cur_sum});
                end
                // reorder the same set for every product
                for (int j = width - 1; j > 0; j--)
                begin
                    pos = $urandom_range(j);
                    tmp = term_vars[j];
                    term_vars[j] = term_vars[pos];
                    term_vars[pos] = tmp;
                end
                foreach (term_vars[j])
                begin
                    repeat ($urandom_range(3) == 0 ? $urandom_range(1, 2) : 0)
                        push_char({1'b0, cur_neg});
                    push_char(term_vars[j]);
                end
            end
            if (kind >= 60)
            begin
                case ($urandom_range(6))
                    0: expr_q.insert($urandom_range(expr_q.size()), 8'($urandom_range(255)));
                    1: expr_q.push_back({1'b0, cur_neg});
                    2: expr_q.push_front({1'b0, cur_sum});
                    3: expr_q.push_back({1'b0, cur_sum});
                    4: expr_q.insert($urandom_range(expr_q.size()), {1'b0, cur_sum});
                    5: expr_q.push_back(term_vars[0]);
                    default:
                    begin
                        // one more variable in the last product only
                        if (accepted.size() > width)
                            expr_q.push_back(accepted[width]);
                        else
                            expr_q.push_back(term_vars[0]);
                    end
                endcase
            end
        end
    endtask

    initial
    begin : stimulus
        int sent;
        int next_cfg;
        int setting;
        sent     = 0;
        next_cfg = 0;
        setting  = 1;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset configuration: at least one expression per status
        expr_q.delete(); push_text(" ");      send_expr();   // spaces only
        expr_q.delete(); push_text("'AB+BA"); send_expr();   // ok, reordered set
        expr_q.delete(); push_text("+A");     send_expr();   // sum at the start
        expr_q.delete(); push_text("A++A");   send_expr();   // empty term
        expr_q.delete(); push_text("A'");     send_expr();   // trailing negation
        expr_q.delete(); push_text("AA");     send_expr();   // repeated variable
        expr_q.delete(); push_text("A+B");    send_expr();   // sets differ
        expr_q.delete(); push_text("A+");     send_expr();   // sum at the end
        expr_q.delete(); expr_q.push_back(8'hFF); send_expr(); // top of the byte range

        // Random part: switch registers every so often, idle profile by thirds
        while (sent < RANDOM_CHARS)
        begin
            if (sent >= (2 * RANDOM_CHARS) / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (sent >= RANDOM_CHARS / 3)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 17;
            end
            if (sent >= next_cfg)
            begin
                wait_drained();
                apply_setting(setting);
                setting  = (setting + 1) % SETTING_COUNT;
                next_cfg = next_cfg + CFG_SWITCH;
            end
            build_random_expr();
            sent = sent + expr_q.size();
            send_expr();
        end

        wait_drained();
        if ((failures == 0) && (pending == 0))
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

FILE: sum_of_products_validator.f
src/sop_pkg.sv
src/sop_classify.sv
src/sop_core.sv
src/sum_of_products_validator.sv
sim/sop_status_checker.sv
sim/tb.sv
